>>> rtl/lane_line_segment_averager_unit_macros.svh
// ----------------------------------------------------------------------------
// Lane line averager assertion macros
// Shared property forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LANE_LINE_SEGMENT_AVERAGER_UNIT_MACROS_SVH
`define LANE_LINE_SEGMENT_AVERAGER_UNIT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define LLSA_HOLDS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("lane averager check failed");

// Antecedent at one edge implies consequent at the next.
`define LLSA_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lane averager check failed");

`endif

>>> rtl/llsa_pkg.sv
// ----------------------------------------------------------------------------
// Lane line averager package
// Widths, sequencer states and saturation helper.
// ----------------------------------------------------------------------------
package llsa_pkg;

    localparam int COORD_BITS      = 12;
    localparam int SLOPE_FRAC_BITS = 8;
    localparam int HISTORY_DEPTH   = 11;
    localparam int CFG_W           = 12;
    localparam int OUT_W           = 17;
    localparam int SLOPE_W         = COORD_BITS + SLOPE_FRAC_BITS + 1;
    localparam int PROD_W          = 2 * SLOPE_W;
    localparam int SUM_W           = 40;
    localparam int CNT_W           = 16;
    localparam int HSUM_W          = 32;
    localparam int DIV_AW          = SUM_W + 1;
    localparam int DIV_QW          = SUM_W;
    localparam int DIV_BW          = SLOPE_W + 1;
    localparam int DIV_CW          = $clog2(DIV_QW);
    localparam logic [CFG_W-1:0] ROWS_RESET = CFG_W'(480);
    localparam logic [CFG_W-1:0] COLS_RESET = CFG_W'(640);
    localparam logic [CNT_W-1:0] CNT_FULL   = '1;

    localparam logic REQ_SEGMENT   = 1'b0;
    localparam logic REQ_FRAME_END = 1'b1;
    localparam logic CFG_ROWS      = 1'b0;
    localparam logic CFG_COLS      = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SDIV,
        S_MUL1,
        S_ILAUNCH,
        S_IDIV,
        S_F_START,
        S_F_MSDIV,
        S_F_MIDIV,
        S_F_RD,
        S_F_UPD,
        S_F_SSLAUNCH,
        S_F_SSDIV,
        S_F_SIDIV,
        S_F_MUL,
        S_F_TLAUNCH,
        S_F_TDIV,
        S_F_NEXT,
        S_EMIT
    } t_state;

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [DIV_AW-1:0] v);
        logic signed [DIV_AW-1:0] lo;
        logic signed [DIV_AW-1:0] hi;
        lo = -(DIV_AW'(1) <<< (OUT_W - 1));
        hi = (DIV_AW'(1) <<< (OUT_W - 1)) - DIV_AW'(1);
        if (v < lo) return lo[OUT_W-1:0];
        if (v > hi) return hi[OUT_W-1:0];
        return v[OUT_W-1:0];
    endfunction

endpackage

>>> rtl/lane_line_segment_averager_unit.sv
// Segment request: two 40-step divisions, a multiply and setup between accepts; a
// degenerate segment skips them all and a shallow one stops after the slope division.
// Frame-end request: up to five divisions per nonempty side through one shared
// divider, none with both sides empty.
// The result sits in an output register; segments are accepted while it waits.
// Synchronous active-low reset clears control, sums, fills and heads.
// ----------------------------------------------------------------------------
// Lane line segment averager
// Classes segments into left/right lane lines and smooths per-frame lines.
// ----------------------------------------------------------------------------
module lane_line_segment_averager_unit #(
    parameter int HISTORY_DEPTH = llsa_pkg::HISTORY_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_idx,
    input  logic [llsa_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_req_type,
    input  logic [llsa_pkg::COORD_BITS-1:0]     i_x_start,
    input  logic [llsa_pkg::COORD_BITS-1:0]     i_y_start,
    input  logic [llsa_pkg::COORD_BITS-1:0]     i_x_end,
    input  logic [llsa_pkg::COORD_BITS-1:0]     i_y_end,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_left_found,
    output logic signed [llsa_pkg::OUT_W-1:0]   o_left_x_top,
    output logic signed [llsa_pkg::OUT_W-1:0]   o_left_x_bottom,
    output logic                                o_right_found,
    output logic signed [llsa_pkg::OUT_W-1:0]   o_right_x_top,
    output logic signed [llsa_pkg::OUT_W-1:0]   o_right_x_bottom
);
    import llsa_pkg::*;

    localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
    localparam int IDX_W  = $clog2(HISTORY_DEPTH);
    localparam int ENT_W  = SLOPE_W + OUT_W;
    localparam logic [FILL_W-1:0] DEPTH_F = FILL_W'(HISTORY_DEPTH);
    localparam logic [IDX_W-1:0]  LAST_I  = IDX_W'(HISTORY_DEPTH - 1);

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_rows, r_cols;

    logic [COORD_BITS-1:0]           r_x0, r_y0, n_x0, n_y0;
    logic signed [SLOPE_W-1:0]       r_slope, n_slope;
    logic signed [PROD_W-1:0]        r_prod, n_prod;
    logic                            r_side, n_side;
    logic signed [SUM_W-1:0]         r_ssum [2];
    logic signed [SUM_W-1:0]         r_isum [2];
    logic [CNT_W-1:0]                r_cnt  [2];
    logic signed [HSUM_W-1:0]        r_hs   [2];
    logic signed [HSUM_W-1:0]        r_hi   [2];
    logic [FILL_W-1:0]               r_fill [2];
    logic [IDX_W-1:0]                r_head [2];
    logic signed [SLOPE_W-1:0]       r_mslope, n_mslope, r_sslope, n_sslope;
    logic signed [OUT_W-1:0]         r_micpt, n_micpt, r_sicpt, n_sicpt;
    logic [IDX_W-1:0]                r_slot, n_slot;
    logic [ENT_W-1:0]                r_rd;
    logic [ENT_W-1:0]                r_mem [2][HISTORY_DEPTH];
    logic                            r_found [2];
    logic signed [OUT_W-1:0]         r_top [2], r_bot [2];
    logic                            n_found, n_res_we;
    logic signed [OUT_W-1:0]         n_top, n_bot;

    logic                            acc_l, acc_r, frame_clr, hist_upd, emit_go;

    // shared divider
    logic                            dv_start;
    logic signed [DIV_AW-1:0]        dv_a, dv_mag_a_s, dv_res;
    logic signed [DIV_BW-1:0]        dv_b, dv_mag_b_s;
    logic [DIV_QW-1:0]               r_dv_q;
    logic [DIV_BW-2:0]               r_dv_b, r_dv_rem;
    logic [DIV_BW-1:0]               dv_trial;
    logic                            r_dv_neg, r_dv_busy, r_dv_done;
    logic [DIV_CW-1:0]               r_dv_cnt;

    logic signed [COORD_BITS:0]      dx, dy, rows_y0;
    logic signed [SLOPE_W-1:0]       half, slope_q;
    logic signed [OUT_W-1:0]         icpt_q, mid;
    logic signed [HSUM_W-1:0]        hs_new, hi_new;
    logic [FILL_W-1:0]               fill_cur;
    logic [IDX_W-1:0]                head_cur;
    logic [FILL_W:0]                 slot_sum;

    assign o_stall = (r_state != S_IDLE);

    assign dx = $signed({1'b0, i_x_end}) - $signed({1'b0, i_x_start});
    assign dy = $signed({1'b0, i_y_end}) - $signed({1'b0, i_y_start});
    assign rows_y0 = $signed({1'b0, r_rows}) - $signed({1'b0, r_y0});
    assign half = SLOPE_W'(1) <<< (SLOPE_FRAC_BITS - 1);
    assign slope_q = dv_res[SLOPE_W-1:0];
    assign icpt_q = sat_out(dv_res);
    assign mid = $signed({{(OUT_W-CFG_W+1){1'b0}}, r_cols[CFG_W-1:1]});
    assign fill_cur = r_fill[r_side];
    assign head_cur = r_head[r_side];
    assign slot_sum = {1'b0, FILL_W'(head_cur)} + {1'b0, fill_cur};
    assign emit_go = (r_state == S_EMIT) && !(o_valid && i_stall);

    always_comb begin
        hs_new = r_hs[r_side] + HSUM_W'(r_mslope);
        hi_new = r_hi[r_side] + HSUM_W'(r_micpt);
        if (fill_cur >= DEPTH_F) begin
            hs_new = hs_new - HSUM_W'($signed(r_rd[ENT_W-1:OUT_W]));
            hi_new = hi_new - HSUM_W'($signed(r_rd[OUT_W-1:0]));
        end
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_x0     = r_x0;
        n_y0     = r_y0;
        n_slope  = r_slope;
        n_prod   = r_prod;
        n_side   = r_side;
        n_mslope = r_mslope;
        n_micpt  = r_micpt;
        n_sslope = r_sslope;
        n_sicpt  = r_sicpt;
        n_slot   = r_slot;
        n_found  = 1'b0;
        n_top    = '0;
        n_bot    = '0;
        n_res_we = 1'b0;
        acc_l    = 1'b0;
        acc_r    = 1'b0;
        hist_upd = 1'b0;
        dv_start = 1'b0;
        dv_a     = '0;
        dv_b     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_req_type == REQ_FRAME_END) begin
                        n_side  = 1'b0;
                        n_state = S_F_START;
                    end else if (dx != 0 && dy != 0) begin
                        n_x0     = i_x_start;
                        n_y0     = i_y_start;
                        dv_start = 1'b1;
                        dv_a     = DIV_AW'(dy) <<< SLOPE_FRAC_BITS;
                        dv_b     = DIV_BW'(dx);
                        n_state  = S_SDIV;
                    end
                end
            end
            S_SDIV: begin
                if (r_dv_done) begin
                    n_slope = slope_q;
                    if (slope_q >= -half && slope_q <= half) n_state = S_IDLE;
                    else n_state = S_MUL1;
                end
            end
            S_MUL1: begin
                n_prod  = PROD_W'(r_slope * $signed({{(SLOPE_W-COORD_BITS){1'b0}}, r_x0}));
                n_state = S_ILAUNCH;
            end
            S_ILAUNCH: begin
                dv_start = 1'b1;
                dv_a     = (DIV_AW'(rows_y0) <<< SLOPE_FRAC_BITS) + DIV_AW'(r_prod);
                dv_b     = DIV_BW'(r_slope);
                n_state  = S_IDIV;
            end
            S_IDIV: begin
                if (r_dv_done) begin
                    acc_l   = (r_slope < -half) && (icpt_q < mid);
                    acc_r   = (r_slope > half) && (icpt_q > mid);
                    n_state = S_IDLE;
                end
            end
            S_F_START: begin
                if (r_cnt[r_side] == '0) begin
                    n_res_we = 1'b1;
                    n_state  = S_F_NEXT;
                end else begin
                    dv_start = 1'b1;
                    dv_a     = DIV_AW'(r_ssum[r_side]);
                    dv_b     = $signed({{(DIV_BW-CNT_W){1'b0}}, r_cnt[r_side]});
                    n_state  = S_F_MSDIV;
                end
            end
            S_F_MSDIV: begin
                if (r_dv_done) begin
                    n_mslope = slope_q;
                    dv_start = 1'b1;
                    dv_a     = DIV_AW'(r_isum[r_side]);
                    dv_b     = $signed({{(DIV_BW-CNT_W){1'b0}}, r_cnt[r_side]});
                    n_state  = S_F_MIDIV;
                end
            end
            S_F_MIDIV: begin
                if (r_dv_done) begin
                    n_micpt = dv_res[OUT_W-1:0];
                    if (fill_cur >= DEPTH_F) n_slot = head_cur;
                    else if (slot_sum >= (FILL_W+1)'(HISTORY_DEPTH))
                        n_slot = IDX_W'(slot_sum - (FILL_W+1)'(HISTORY_DEPTH));
                    else n_slot = IDX_W'(slot_sum);
                    n_state = S_F_RD;
                end
            end
            S_F_RD: begin
                n_state = S_F_UPD;
            end
            S_F_UPD: begin
                hist_upd = 1'b1;
                n_state  = S_F_SSLAUNCH;
            end
            S_F_SSLAUNCH: begin
                dv_start = 1'b1;
                dv_a     = DIV_AW'(r_hs[r_side]);
                dv_b     = $signed({{(DIV_BW-FILL_W){1'b0}}, fill_cur});
                n_state  = S_F_SSDIV;
            end
            S_F_SSDIV: begin
                if (r_dv_done) begin
                    n_sslope = slope_q;
                    dv_start = 1'b1;
                    dv_a     = DIV_AW'(r_hi[r_side]);
                    dv_b     = $signed({{(DIV_BW-FILL_W){1'b0}}, fill_cur});
                    n_state  = S_F_SIDIV;
                end
            end
            S_F_SIDIV: begin
                if (r_dv_done) begin
                    n_sicpt = icpt_q;
                    n_state = S_F_MUL;
                end
            end
            S_F_MUL: begin
                n_prod  = PROD_W'(r_sslope * SLOPE_W'(r_sicpt));
                n_state = S_F_TLAUNCH;
            end
            S_F_TLAUNCH: begin
                if (r_sslope == '0) begin
                    n_res_we = 1'b1;
                    n_found  = 1'b1;
                    n_top    = r_sicpt;
                    n_bot    = r_sicpt;
                    n_state  = S_F_NEXT;
                end else begin
                    dv_start = 1'b1;
                    dv_a     = DIV_AW'(r_prod)
                             - (DIV_AW'($signed({1'b0, r_rows})) <<< SLOPE_FRAC_BITS);
                    dv_b     = DIV_BW'(r_sslope);
                    n_state  = S_F_TDIV;
                end
            end
            S_F_TDIV: begin
                if (r_dv_done) begin
                    n_res_we = 1'b1;
                    n_found  = 1'b1;
                    n_top    = icpt_q;
                    n_bot    = r_sicpt;
                    n_state  = S_F_NEXT;
                end
            end
            S_F_NEXT: begin
                if (!r_side) begin
                    n_side  = 1'b1;
                    n_state = S_F_START;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // hold until the output register frees
                if (emit_go) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign frame_clr = emit_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rows  <= ROWS_RESET;
            r_cols  <= COLS_RESET;
            r_side  <= 1'b0;
            o_valid <= 1'b0;
            for (int s = 0; s < 2; s++) begin
                r_ssum[s] <= '0;
                r_isum[s] <= '0;
                r_cnt[s]  <= '0;
                r_hs[s]   <= '0;
                r_hi[s]   <= '0;
                r_fill[s] <= '0;
                r_head[s] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_side  <= n_side;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_ROWS) r_rows <= i_cfg_data;
                else r_cols <= i_cfg_data;
            end
            if (emit_go) o_valid <= 1'b1;
            else if (!i_stall) o_valid <= 1'b0;
            if (frame_clr) begin
                for (int s = 0; s < 2; s++) begin
                    r_ssum[s] <= '0;
                    r_isum[s] <= '0;
                    r_cnt[s]  <= '0;
                end
            end else begin
                if (acc_l && r_cnt[0] != CNT_FULL) begin
                    r_ssum[0] <= r_ssum[0] + SUM_W'(r_slope);
                    r_isum[0] <= r_isum[0] + SUM_W'(icpt_q);
                    r_cnt[0]  <= r_cnt[0] + CNT_W'(1);
                end
                if (acc_r && r_cnt[1] != CNT_FULL) begin
                    r_ssum[1] <= r_ssum[1] + SUM_W'(r_slope);
                    r_isum[1] <= r_isum[1] + SUM_W'(icpt_q);
                    r_cnt[1]  <= r_cnt[1] + CNT_W'(1);
                end
            end
            if (hist_upd) begin
                r_hs[r_side] <= hs_new;
                r_hi[r_side] <= hi_new;
                if (fill_cur >= DEPTH_F) begin
                    r_head[r_side] <= (head_cur == LAST_I) ? '0 : head_cur + IDX_W'(1);
                end else begin
                    r_fill[r_side] <= fill_cur + FILL_W'(1);
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_x0     <= n_x0;
        r_y0     <= n_y0;
        r_slope  <= n_slope;
        r_prod   <= n_prod;
        r_mslope <= n_mslope;
        r_micpt  <= n_micpt;
        r_sslope <= n_sslope;
        r_sicpt  <= n_sicpt;
        r_slot   <= n_slot;
        if (n_res_we) begin
            r_found[r_side] <= n_found;
            r_top[r_side]   <= n_top;
            r_bot[r_side]   <= n_bot;
        end
        if (emit_go) begin
            o_left_found     <= r_found[0];
            o_left_x_top     <= r_top[0];
            o_left_x_bottom  <= r_bot[0];
            o_right_found    <= r_found[1];
            o_right_x_top    <= r_top[1];
            o_right_x_bottom <= r_bot[1];
        end
    end

    // history ring memory
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_side][r_slot];
        if (hist_upd) r_mem[r_side][r_slot] <= {r_mslope, r_micpt};
    end

    // shared restoring divider, one quotient bit per cycle, truncates to zero
    assign dv_mag_a_s = dv_a[DIV_AW-1] ? -dv_a : dv_a;
    assign dv_mag_b_s = dv_b[DIV_BW-1] ? -dv_b : dv_b;
    assign dv_trial   = {r_dv_rem, r_dv_q[DIV_QW-1]};
    assign dv_res     = r_dv_neg ? -$signed({1'b0, r_dv_q}) : $signed({1'b0, r_dv_q});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_busy <= 1'b0;
            r_dv_done <= 1'b0;
            r_dv_cnt  <= '0;
        end else begin
            r_dv_done <= 1'b0;
            if (dv_start) begin
                r_dv_busy <= 1'b1;
                r_dv_cnt  <= '0;
            end else if (r_dv_busy) begin
                r_dv_cnt <= r_dv_cnt + DIV_CW'(1);
                if (r_dv_cnt == DIV_CW'(DIV_QW - 1)) begin
                    r_dv_busy <= 1'b0;
                    r_dv_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (dv_start) begin
            r_dv_q   <= dv_mag_a_s[DIV_QW-1:0];
            r_dv_b   <= dv_mag_b_s[DIV_BW-2:0];
            r_dv_rem <= '0;
            r_dv_neg <= dv_a[DIV_AW-1] ^ dv_b[DIV_BW-1];
        end else if (r_dv_busy) begin
            if (dv_trial >= {1'b0, r_dv_b}) begin
                r_dv_rem <= (DIV_BW-1)'(dv_trial - {1'b0, r_dv_b});
                r_dv_q   <= {r_dv_q[DIV_QW-2:0], 1'b1};
            end else begin
                r_dv_rem <= dv_trial[DIV_BW-2:0];
                r_dv_q   <= {r_dv_q[DIV_QW-2:0], 1'b0};
            end
        end
    end

`include "lane_line_segment_averager_unit_macros.svh"

    `LLSA_HOLDS(a_fill_bound, r_fill[0] <= DEPTH_F && r_fill[1] <= DEPTH_F)
    `LLSA_HOLDS(a_head_bound, r_head[0] <= LAST_I && r_head[1] <= LAST_I)
    `LLSA_HOLDS(a_div_idle_launch, !(dv_start && r_dv_busy))
    `LLSA_NEXT(a_frame_cleared, emit_go, r_cnt[0] == '0 && r_cnt[1] == '0 && o_valid)

endmodule
